/* sv/pnc_pkg.sv */
// shared type and novelty level codes for the pair novelty checker
package pnc_pkg;

  typedef logic [1:0] level_t;

  localparam level_t NOV_SINGLE = 2'd1;
  localparam level_t NOV_PAIR   = 2'd2;
  localparam level_t NOV_NONE   = 2'd3;

endpackage

/* sv/pair_novelty_checker.sv */
// pair novelty checker: single and pair bit tables with a shared access sequencer
// an item with a stone reads the single table once and the pair table once per stored
// earlier stone, and an item without one reads neither; the pair table port does one
// read per cycle, pipelined against the write-back of the previous row
// the result is loaded into the output register on the last cycle of the final item
// after reset a clearing pass over all H_LEVELS*FREE_SQUARES^2 pair rows zeroes both tables
module pair_novelty_checker #(
  parameter int H_LEVELS     = 256,
  parameter int FREE_SQUARES = 16,
  parameter int MAX_STONES   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_heur_value,
  input  logic [3:0]      in_man_square,
  input  logic [3:0]      in_stone_square,
  input  logic            in_stone_valid,
  input  logic            in_last_stone,
  output logic            out_valid,
  input  logic            out_stall,
  output pnc_pkg::level_t out_novelty_level
);

  import pnc_pkg::*;

  localparam int HW          = $clog2(H_LEVELS);
  localparam int SW          = $clog2(FREE_SQUARES);
  localparam int SINGLE_ROWS = H_LEVELS * FREE_SQUARES;
  localparam int PAIR_ROWS   = H_LEVELS * FREE_SQUARES * FREE_SQUARES;
  localparam int SAW         = $clog2(SINGLE_ROWS);
  localparam int PAW         = $clog2(PAIR_ROWS);
  localparam int IW          = (MAX_STONES > 1) ? $clog2(MAX_STONES) : 1;
  localparam int KW          = $clog2(MAX_STONES + 1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_ACCESS = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  // remainder of a narrow value, quotient known to stay below 16
  function automatic logic [7:0] mod_small(input logic [7:0] v, input int unsigned m);
    logic [7:0] r;
    r = v;
    for (int s = 3; s >= 0; s--) begin
      if ({24'd0, r} >= (m << s)) begin
        r = r - 8'(m << s);
      end
    end
    return r;
  endfunction

  logic [1:0]              state_r, state_nxt;
  logic [PAW-1:0]          clr_cnt_r, clr_cnt_nxt;
  logic [HW-1:0]           h_r;
  logic [SW-1:0]           man_r, stone_r;
  logic                    item_vld_r, item_last_r;
  logic                    first_r, first_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic [KW-1:0]           held_r, held_nxt;
  logic [SW-1:0]           store_r [MAX_STONES];
  logic                    found_single_r, found_single_nxt;
  logic                    found_pair_r, found_pair_nxt;
  logic                    p_vld_r, s_vld_r;
  logic [PAW-1:0]          p_addr_r;
  logic                    byp_r;
  logic [FREE_SQUARES-1:0] byp_data_r;
  logic                    out_valid_r;
  level_t                  out_level_r;

  logic                    accept;
  logic                    issue_pair, issue_single;
  logic [SAW-1:0]          s_addr, e_row;
  logic [PAW-1:0]          p_raddr;
  logic [FREE_SQUARES-1:0] pair_rd, pair_eff, pair_set, single_rd;
  logic [FREE_SQUARES-1:0] man_mask;
  logic                    pair_we, single_we;
  logic [PAW-1:0]          pair_waddr;
  logic [SAW-1:0]          single_waddr;
  logic [FREE_SQUARES-1:0] pair_wdata, single_wdata;
  logic                    drained, out_free, store_wr;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign man_mask = FREE_SQUARES'(1) << man_r;
  assign s_addr   = SAW'(h_r) * SAW'(FREE_SQUARES) + SAW'(stone_r);
  assign e_row    = SAW'(h_r) * SAW'(FREE_SQUARES) + SAW'(store_r[k_r[IW-1:0]]);
  assign p_raddr  = PAW'(e_row) * PAW'(FREE_SQUARES) + PAW'(stone_r);

  assign issue_pair   = (state_r == ST_ACCESS) && item_vld_r && (k_r < held_r);
  assign issue_single = (state_r == ST_ACCESS) && item_vld_r && first_r;
  assign drained      = !issue_pair && !issue_single && !p_vld_r && !s_vld_r;

  assign pair_eff = byp_r ? byp_data_r : pair_rd;
  assign pair_set = pair_eff | man_mask;

  // clearing pass shares the write ports with the write-back
  always_comb begin
    if (state_r == ST_CLEAR) begin
      pair_we      = 1'b1;
      pair_waddr   = clr_cnt_r;
      pair_wdata   = '0;
      single_we    = (clr_cnt_r < PAW'(SINGLE_ROWS));
      single_waddr = clr_cnt_r[SAW-1:0];
      single_wdata = '0;
    end else begin
      pair_we      = p_vld_r;
      pair_waddr   = p_addr_r;
      pair_wdata   = pair_set;
      single_we    = s_vld_r;
      single_waddr = s_addr;
      single_wdata = single_rd | man_mask;
    end
  end

  pnc_bit_ram #(
    .DEPTH(PAIR_ROWS),
    .WIDTH(FREE_SQUARES)
  ) u_pair_ram (
    .clk  (clk),
    .we   (pair_we),
    .waddr(pair_waddr),
    .wdata(pair_wdata),
    .re   (issue_pair),
    .raddr(p_raddr),
    .rdata(pair_rd)
  );

  pnc_bit_ram #(
    .DEPTH(SINGLE_ROWS),
    .WIDTH(FREE_SQUARES)
  ) u_single_ram (
    .clk  (clk),
    .we   (single_we),
    .waddr(single_waddr),
    .wdata(single_wdata),
    .re   (issue_single),
    .raddr(s_addr),
    .rdata(single_rd)
  );

  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    first_nxt        = first_r;
    k_nxt            = k_r;
    held_nxt         = held_r;
    found_single_nxt = found_single_r;
    found_pair_nxt   = found_pair_r;
    store_wr         = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + PAW'(1);
        if (clr_cnt_r == PAW'(PAIR_ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_ACCESS;
          first_nxt = 1'b1;
          k_nxt     = '0;
        end
      end
      ST_ACCESS: begin
        first_nxt = 1'b0;
        if (issue_pair) begin
          k_nxt = k_r + KW'(1);
        end
        if (s_vld_r && !single_rd[man_r]) begin
          found_single_nxt = 1'b1;
        end
        if (p_vld_r && !pair_eff[man_r]) begin
          found_pair_nxt = 1'b1;
        end
        if (drained) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!item_last_r || out_free) begin
          state_nxt = ST_IDLE;
          if (item_vld_r && (held_r < KW'(MAX_STONES))) begin
            store_wr = 1'b1;
            held_nxt = held_r + KW'(1);
          end
          if (item_last_r) begin
            held_nxt         = '0;
            found_single_nxt = 1'b0;
            found_pair_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_cnt_r      <= '0;
      first_r        <= 1'b0;
      k_r            <= '0;
      held_r         <= '0;
      found_single_r <= 1'b0;
      found_pair_r   <= 1'b0;
      p_vld_r        <= 1'b0;
      s_vld_r        <= 1'b0;
      byp_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      first_r        <= first_nxt;
      k_r            <= k_nxt;
      held_r         <= held_nxt;
      found_single_r <= found_single_nxt;
      found_pair_r   <= found_pair_nxt;
      p_vld_r        <= issue_pair;
      s_vld_r        <= issue_single;
      // read of the row written in the same cycle returns stale data
      byp_r          <= issue_pair && p_vld_r && (p_raddr == p_addr_r);
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == ST_DONE) && item_last_r && out_free) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_r         <= HW'(mod_small(in_heur_value, H_LEVELS));
      man_r       <= SW'(mod_small({4'd0, in_man_square}, FREE_SQUARES));
      stone_r     <= SW'(mod_small({4'd0, in_stone_square}, FREE_SQUARES));
      item_vld_r  <= in_stone_valid;
      item_last_r <= in_last_stone;
    end
    p_addr_r   <= p_raddr;
    byp_data_r <= pair_set;
    if (store_wr) begin
      store_r[held_r[IW-1:0]] <= stone_r;
    end
    if ((state_r == ST_DONE) && item_last_r && out_free) begin
      if (found_single_r) begin
        out_level_r <= NOV_SINGLE;
      end else if (found_pair_r) begin
        out_level_r <= NOV_PAIR;
      end else begin
        out_level_r <= NOV_NONE;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_novelty_level = out_level_r;

endmodule

/* sv/pnc_bit_ram.sv */
// row-organized bit table, one write port and one registered read port
module pnc_bit_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
